FILE: src/asci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asci_pkg
// Shared types, register codes and helpers of the agent seek, clamp and
// integrate pipeline.
// ----------------------------------------------------------------------------
package asci_pkg;

  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 31;

  localparam logic [2:0] REG_MAX_SPEED    = 3'd0;
  localparam logic [2:0] REG_WORLD_EXTENT = 3'd1;
  localparam logic [2:0] REG_SEEK_ACCEL   = 3'd2;
  localparam logic [2:0] REG_SEEK_ENABLE  = 3'd3;
  localparam logic [2:0] REG_LOCK_Z       = 3'd4;
  localparam logic [2:0] REG_GROUND_LEVEL = 3'd5;

  localparam logic [30:0] MAX_SPEED_RST    = 31'd39321600;
  localparam logic [30:0] WORLD_EXTENT_RST = 31'd655360000;

  typedef struct packed {
    logic             alive;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [15:0]      dt;
  } item_t;

  // two's complement 34 bit value to saturated 32 bit
  function automatic logic [31:0] sat32(input logic [33:0] x);
    logic [31:0] r;
    r = x[31:0];
    if (!x[33] && (x[32:31] != 2'b00)) r = 32'h7fff_ffff;
    if (x[33] && (x[32:31] != 2'b11)) r = 32'h8000_0000;
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

endpackage

FILE: src/asci_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asci_delay
// Fixed delay line for a valid bit and its side data.
// ----------------------------------------------------------------------------
module asci_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data
);

  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] dat [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i < DEPTH; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    dat[0] <= in_data;
    for (int i = 1; i < DEPTH; i++) dat[i] <= dat[i-1];
  end

  assign out_valid = vld[DEPTH-1];
  assign out_data  = dat[DEPTH-1];

endmodule

FILE: src/asci_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asci_sqrt
// Pipelined 64 bit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module asci_sqrt (
  input  logic        clk,
  input  logic [63:0] x,
  output logic [31:0] root
);

  logic [63:0] xs [1:asci_pkg::SQRT_STAGES];
  logic [63:0] rs [1:asci_pkg::SQRT_STAGES];

  for (genvar k = 0; k < asci_pkg::SQRT_STAGES; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] xc;
    logic [63:0] rc;
    logic [63:0] trial;
    if (k == 0) begin : g_first
      assign xc = x;
      assign rc = '0;
    end else begin : g_rest
      assign xc = xs[k];
      assign rc = rs[k];
    end
    assign trial = rc + BIT;
    always_ff @(posedge clk) begin
      if (xc >= trial) begin
        xs[k+1] <= xc - trial;
        rs[k+1] <= (rc >> 1) + BIT;
      end else begin
        xs[k+1] <= xc;
        rs[k+1] <= rc >> 1;
      end
    end
  end

  assign root = rs[asci_pkg::SQRT_STAGES][31:0];

endmodule

FILE: src/asci_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asci_div
// Pipelined restoring divider, one quotient bit per stage. The upper part
// of the dividend must be below the divisor.
// ----------------------------------------------------------------------------
module asci_div (
  input  logic        clk,
  input  logic [31:0] rem_in,
  input  logic [30:0] low_in,
  input  logic [31:0] den,
  output logic [30:0] quo
);

  logic [31:0] rs [1:asci_pkg::DIV_STAGES];
  logic [30:0] ls [1:asci_pkg::DIV_STAGES];
  logic [30:0] qs [1:asci_pkg::DIV_STAGES];
  logic [31:0] ds [1:asci_pkg::DIV_STAGES];

  for (genvar k = 0; k < asci_pkg::DIV_STAGES; k++) begin : g_step
    logic [31:0] rc;
    logic [30:0] lc;
    logic [30:0] qc;
    logic [31:0] dc;
    logic [32:0] t;
    if (k == 0) begin : g_first
      assign rc = rem_in;
      assign lc = low_in;
      assign qc = '0;
      assign dc = den;
    end else begin : g_rest
      assign rc = rs[k];
      assign lc = ls[k];
      assign qc = qs[k];
      assign dc = ds[k];
    end
    assign t = {rc, lc[30]};
    always_ff @(posedge clk) begin
      ls[k+1] <= {lc[29:0], 1'b0};
      ds[k+1] <= dc;
      if (t >= {1'b0, dc}) begin
        rs[k+1] <= 32'(t - {1'b0, dc});
        qs[k+1] <= {qc[29:0], 1'b1};
      end else begin
        rs[k+1] <= t[31:0];
        qs[k+1] <= {qc[29:0], 1'b0};
      end
    end
  end

  assign quo = qs[asci_pkg::DIV_STAGES];

endmodule

FILE: src/agent_seek_clamp_integrate_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agent_seek_clamp_integrate_top
// Agent update: optional seek toward a target, speed clamp, Euler step,
// z lock and bounce at the world box, in signed Q16.16.
// ----------------------------------------------------------------------------
// One agent word is taken every cycle (busy stays low) and its result shows
// on done in order. Most of the pipeline depth comes from two 32 stage
// square roots and two 31 stage dividers in series.
// done is a one cycle strobe and cannot be held off, so the receiver must
// take every word when it appears. Registers are written with cfg_we and must
// only change while no word is in flight.
module agent_seek_clamp_integrate_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [31:0] vel_x,
  input  logic [31:0] vel_y,
  input  logic [31:0] vel_z,
  input  logic        alive,
  input  logic [31:0] target_x,
  input  logic [31:0] target_y,
  input  logic [31:0] target_z,
  input  logic [15:0] time_step,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [31:0] new_pos_x,
  output logic [31:0] new_pos_y,
  output logic [31:0] new_pos_z,
  output logic [31:0] new_vel_x,
  output logic [31:0] new_vel_y,
  output logic [31:0] new_vel_z
);

  typedef struct packed {
    asci_pkg::item_t  item;
    logic [2:0]       neg;
    logic [2:0][30:0] ms;
    logic             far;
  } seek_pay_t;

  typedef struct packed {
    asci_pkg::item_t item;
    logic [2:0]      neg;
    logic            far;
  } seek_div_pay_t;

  typedef struct packed {
    asci_pkg::item_t  item;
    logic [2:0][31:0] mag;
    logic             clamp;
  } clamp_pay_t;

  typedef struct packed {
    asci_pkg::item_t item;
    logic            clamp;
  } clamp_div_pay_t;

  logic [30:0] max_speed;
  logic [30:0] world_extent;
  logic [30:0] seek_accel;
  logic        seek_enable;
  logic        lock_z;
  logic [31:0] ground_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed    <= asci_pkg::MAX_SPEED_RST;
      world_extent <= asci_pkg::WORLD_EXTENT_RST;
      seek_accel   <= '0;
      seek_enable  <= 1'b0;
      lock_z       <= 1'b0;
      ground_level <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        asci_pkg::REG_MAX_SPEED:    max_speed    <= cfg_data[30:0];
        asci_pkg::REG_WORLD_EXTENT: world_extent <= cfg_data[30:0];
        asci_pkg::REG_SEEK_ACCEL:   seek_accel   <= cfg_data[30:0];
        asci_pkg::REG_SEEK_ENABLE:  seek_enable  <= cfg_data[0];
        asci_pkg::REG_LOCK_Z:       lock_z       <= cfg_data[0];
        asci_pkg::REG_GROUND_LEVEL: ground_level <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // input word
  logic             s0_valid;
  asci_pkg::item_t  s0_item;
  logic [2:0][31:0] s0_tgt;

  always_ff @(posedge clk) begin
    if (rst) s0_valid <= 1'b0;
    else s0_valid <= start & ~busy;
  end

  always_ff @(posedge clk) begin
    s0_item.alive <= alive;
    s0_item.pos   <= {pos_z, pos_y, pos_x};
    s0_item.vel   <= {vel_z, vel_y, vel_x};
    s0_item.dt    <= time_step;
    s0_tgt        <= {target_z, target_y, target_x};
  end

  // distance to target
  logic [2:0][32:0] sa_d;
  logic             sa_valid;
  asci_pkg::item_t  sa_item;
  logic [2:0][31:0] sa_m;
  logic [2:0]       sa_neg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sa_d[i] = {s0_tgt[i][31], s0_tgt[i]} - {s0_item.pos[i][31], s0_item.pos[i]};
      if (i == 2 && lock_z) sa_d[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sa_valid <= 1'b0;
    else sa_valid <= s0_valid;
  end

  always_ff @(posedge clk) begin
    sa_item <= s0_item;
    for (int i = 0; i < 3; i++) begin
      sa_neg[i] <= sa_d[i][32];
      sa_m[i]   <= 32'(sa_d[i][32] ? (~sa_d[i] + 33'd1) : sa_d[i]);
    end
  end

  // range reduce, near test squares
  logic             sb_valid;
  asci_pkg::item_t  sb_item;
  logic [2:0]       sb_neg;
  logic [2:0][30:0] sb_ms;
  logic [2:0][33:0] sb_nsq;
  logic             sb_far_big;
  logic             sb_shift;

  assign sb_shift = sa_m[0][31] | sa_m[1][31] | sa_m[2][31];

  always_ff @(posedge clk) begin
    if (rst) sb_valid <= 1'b0;
    else sb_valid <= sa_valid;
  end

  always_ff @(posedge clk) begin
    sb_item    <= sa_item;
    sb_neg     <= sa_neg;
    sb_far_big <= (sa_m[0] > 32'd65536) | (sa_m[1] > 32'd65536) | (sa_m[2] > 32'd65536);
    for (int i = 0; i < 3; i++) begin
      sb_ms[i]  <= sb_shift ? sa_m[i][31:1] : sa_m[i][30:0];
      sb_nsq[i] <= sa_m[i][16:0] * sa_m[i][16:0];
    end
  end

  // squares
  logic             sc_valid;
  asci_pkg::item_t  sc_item;
  logic [2:0]       sc_neg;
  logic [2:0][30:0] sc_ms;
  logic [2:0][61:0] sc_sq;
  logic             sc_far;
  logic [35:0]      sc_near_sum;

  assign sc_near_sum = 36'(sb_nsq[0]) + 36'(sb_nsq[1]) + 36'(sb_nsq[2]);

  always_ff @(posedge clk) begin
    if (rst) sc_valid <= 1'b0;
    else sc_valid <= sb_valid;
  end

  always_ff @(posedge clk) begin
    sc_item <= sb_item;
    sc_neg  <= sb_neg;
    sc_ms   <= sb_ms;
    sc_far  <= sb_far_big | (sc_near_sum > 36'h1_0000_0000);
    for (int i = 0; i < 3; i++) sc_sq[i] <= sb_ms[i] * sb_ms[i];
  end

  // sum of squares into the root
  logic        sd_valid;
  seek_pay_t   sd_pay;
  logic [63:0] sd_sum;

  always_ff @(posedge clk) begin
    if (rst) sd_valid <= 1'b0;
    else sd_valid <= sc_valid;
  end

  always_ff @(posedge clk) begin
    sd_pay.item <= sc_item;
    sd_pay.neg  <= sc_neg;
    sd_pay.ms   <= sc_ms;
    sd_pay.far  <= sc_far;
    sd_sum      <= 64'(sc_sq[0]) + 64'(sc_sq[1]) + 64'(sc_sq[2]);
  end

  logic [31:0] se_root;
  logic        se_valid;
  seek_pay_t   se_pay;
  logic [31:0] se_n;

  asci_sqrt u_seek_sqrt (
    .clk  (clk),
    .x    (sd_sum),
    .root (se_root)
  );

  asci_delay #(
    .WIDTH ($bits(seek_pay_t)),
    .DEPTH (asci_pkg::SQRT_STAGES)
  ) u_seek_sqrt_dly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sd_valid),
    .in_data   (sd_pay),
    .out_valid (se_valid),
    .out_data  (se_pay)
  );

  assign se_n = (se_root == '0) ? 32'd1 : se_root;

  // unit direction
  logic [2:0][30:0] sf_u;
  seek_div_pay_t    se_dpay;
  logic             sf_in_valid;
  seek_div_pay_t    sf_in_pay;

  assign se_dpay.item = se_pay.item;
  assign se_dpay.neg  = se_pay.neg;
  assign se_dpay.far  = se_pay.far;

  for (genvar i = 0; i < 3; i++) begin : g_seek_div
    asci_div u_div (
      .clk    (clk),
      .rem_in ({2'b00, se_pay.ms[i][30:1]}),
      .low_in ({se_pay.ms[i][0], 30'd0}),
      .den    (se_n),
      .quo    (sf_u[i])
    );
  end

  asci_delay #(
    .WIDTH ($bits(seek_div_pay_t)),
    .DEPTH (asci_pkg::DIV_STAGES)
  ) u_seek_div_dly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (se_valid),
    .in_data   (se_dpay),
    .out_valid (sf_in_valid),
    .out_data  (sf_in_pay)
  );

  // gain times accel
  logic             sf_valid;
  seek_div_pay_t    sf_pay;
  logic [2:0][31:0] sf_w;
  logic [2:0][61:0] sf_prod;

  always_comb begin
    for (int i = 0; i < 3; i++) sf_prod[i] = sf_u[i] * seek_accel;
  end

  always_ff @(posedge clk) begin
    if (rst) sf_valid <= 1'b0;
    else sf_valid <= sf_in_valid;
  end

  always_ff @(posedge clk) begin
    sf_pay <= sf_in_pay;
    for (int i = 0; i < 3; i++) sf_w[i] <= sf_prod[i][61:30];
  end

  // times dt
  logic             sg_valid;
  seek_div_pay_t    sg_pay;
  logic [2:0][31:0] sg_g;
  logic [2:0][47:0] sg_prod;

  always_comb begin
    for (int i = 0; i < 3; i++) sg_prod[i] = sf_w[i] * sf_pay.item.dt;
  end

  always_ff @(posedge clk) begin
    if (rst) sg_valid <= 1'b0;
    else sg_valid <= sf_valid;
  end

  always_ff @(posedge clk) begin
    sg_pay <= sf_pay;
    for (int i = 0; i < 3; i++) sg_g[i] <= sg_prod[i][47:16];
  end

  // seek velocity update
  logic             sh_valid;
  asci_pkg::item_t  sh_item;
  asci_pkg::item_t  sh_item_next;
  logic [2:0][33:0] sh_sum;

  always_comb begin
    sh_item_next = sg_pay.item;
    for (int i = 0; i < 3; i++) begin
      if (sg_pay.neg[i]) begin
        sh_sum[i] = {{2{sg_pay.item.vel[i][31]}}, sg_pay.item.vel[i]} - {2'b00, sg_g[i]};
      end else begin
        sh_sum[i] = {{2{sg_pay.item.vel[i][31]}}, sg_pay.item.vel[i]} + {2'b00, sg_g[i]};
      end
      if (sg_pay.item.alive && seek_enable && sg_pay.far && !(i == 2 && lock_z)) begin
        sh_item_next.vel[i] = asci_pkg::sat32(sh_sum[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sh_valid <= 1'b0;
    else sh_valid <= sg_valid;
  end

  always_ff @(posedge clk) begin
    sh_item <= sh_item_next;
  end

  // speed magnitudes
  logic             si_valid;
  asci_pkg::item_t  si_item;
  logic [2:0][31:0] si_mag;

  always_ff @(posedge clk) begin
    if (rst) si_valid <= 1'b0;
    else si_valid <= sh_valid;
  end

  always_ff @(posedge clk) begin
    si_item <= sh_item;
    for (int i = 0; i < 3; i++) si_mag[i] <= asci_pkg::abs32(sh_item.vel[i]);
  end

  // squares of speed
  logic             sj_valid;
  asci_pkg::item_t  sj_item;
  logic [2:0][31:0] sj_mag;
  logic [2:0][63:0] sj_sq;
  logic [61:0]      sj_ms2;

  always_ff @(posedge clk) begin
    if (rst) sj_valid <= 1'b0;
    else sj_valid <= si_valid;
  end

  always_ff @(posedge clk) begin
    sj_item <= si_item;
    sj_mag  <= si_mag;
    sj_ms2  <= max_speed * max_speed;
    for (int i = 0; i < 3; i++) sj_sq[i] <= si_mag[i] * si_mag[i];
  end

  // clamp test
  logic        sk_valid;
  clamp_pay_t  sk_pay;
  logic [63:0] sk_s2;
  logic [63:0] sk_s2_next;

  assign sk_s2_next = sj_sq[0] + sj_sq[1] + sj_sq[2];

  always_ff @(posedge clk) begin
    if (rst) sk_valid <= 1'b0;
    else sk_valid <= sj_valid;
  end

  always_ff @(posedge clk) begin
    sk_pay.item  <= sj_item;
    sk_pay.mag   <= sj_mag;
    sk_pay.clamp <= sj_item.alive & (sk_s2_next > 64'(sj_ms2));
    sk_s2        <= sk_s2_next;
  end

  logic [31:0] sl_root;
  logic        sl_in_valid;
  clamp_pay_t  sl_in_pay;

  asci_sqrt u_clamp_sqrt (
    .clk  (clk),
    .x    (sk_s2),
    .root (sl_root)
  );

  asci_delay #(
    .WIDTH ($bits(clamp_pay_t)),
    .DEPTH (asci_pkg::SQRT_STAGES)
  ) u_clamp_sqrt_dly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sk_valid),
    .in_data   (sk_pay),
    .out_valid (sl_in_valid),
    .out_data  (sl_in_pay)
  );

  // scale by limit
  logic             sl_valid;
  clamp_div_pay_t   sl_pay;
  logic [31:0]      sl_s;
  logic [2:0][62:0] sl_prod;

  always_ff @(posedge clk) begin
    if (rst) sl_valid <= 1'b0;
    else sl_valid <= sl_in_valid;
  end

  always_ff @(posedge clk) begin
    sl_pay.item  <= sl_in_pay.item;
    sl_pay.clamp <= sl_in_pay.clamp;
    sl_s         <= (sl_root == '0) ? 32'd1 : sl_root;
    for (int i = 0; i < 3; i++) sl_prod[i] <= sl_in_pay.mag[i] * max_speed;
  end

  logic [2:0][30:0] sn_q;
  logic             sn_in_valid;
  clamp_div_pay_t   sn_in_pay;

  for (genvar i = 0; i < 3; i++) begin : g_clamp_div
    asci_div u_div (
      .clk    (clk),
      .rem_in (sl_prod[i][62:31]),
      .low_in (sl_prod[i][30:0]),
      .den    (sl_s),
      .quo    (sn_q[i])
    );
  end

  asci_delay #(
    .WIDTH ($bits(clamp_div_pay_t)),
    .DEPTH (asci_pkg::DIV_STAGES)
  ) u_clamp_div_dly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sl_valid),
    .in_data   (sl_pay),
    .out_valid (sn_in_valid),
    .out_data  (sn_in_pay)
  );

  // clamped velocity
  logic            sn_valid;
  asci_pkg::item_t sn_item;
  asci_pkg::item_t sn_item_next;

  always_comb begin
    sn_item_next = sn_in_pay.item;
    for (int i = 0; i < 3; i++) begin
      if (sn_in_pay.clamp) begin
        sn_item_next.vel[i] = sn_in_pay.item.vel[i][31] ? (~{1'b0, sn_q[i]} + 32'd1)
                                                        : {1'b0, sn_q[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sn_valid <= 1'b0;
    else sn_valid <= sn_in_valid;
  end

  always_ff @(posedge clk) begin
    sn_item <= sn_item_next;
  end

  // step magnitudes
  logic             so_valid;
  asci_pkg::item_t  so_item;
  logic [2:0][31:0] so_mag;

  always_ff @(posedge clk) begin
    if (rst) so_valid <= 1'b0;
    else so_valid <= sn_valid;
  end

  always_ff @(posedge clk) begin
    so_item <= sn_item;
    for (int i = 0; i < 3; i++) so_mag[i] <= asci_pkg::abs32(sn_item.vel[i]);
  end

  // distance moved
  logic             sp_valid;
  asci_pkg::item_t  sp_item;
  logic [2:0][31:0] sp_step;
  logic [2:0][47:0] sp_prod;

  always_comb begin
    for (int i = 0; i < 3; i++) sp_prod[i] = so_mag[i] * so_item.dt;
  end

  always_ff @(posedge clk) begin
    if (rst) sp_valid <= 1'b0;
    else sp_valid <= so_valid;
  end

  always_ff @(posedge clk) begin
    sp_item <= so_item;
    for (int i = 0; i < 3; i++) sp_step[i] <= sp_prod[i][47:16];
  end

  // integrate and z lock
  logic             sq_valid;
  asci_pkg::item_t  sq_item;
  asci_pkg::item_t  sq_item_next;
  logic [2:0][33:0] sq_sum;

  always_comb begin
    sq_item_next = sp_item;
    for (int i = 0; i < 3; i++) begin
      if (sp_item.vel[i][31]) begin
        sq_sum[i] = {{2{sp_item.pos[i][31]}}, sp_item.pos[i]} - {2'b00, sp_step[i]};
      end else begin
        sq_sum[i] = {{2{sp_item.pos[i][31]}}, sp_item.pos[i]} + {2'b00, sp_step[i]};
      end
      if (sp_item.alive) sq_item_next.pos[i] = asci_pkg::sat32(sq_sum[i]);
    end
    if (sp_item.alive && lock_z) begin
      sq_item_next.pos[2] = ground_level;
      sq_item_next.vel[2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sq_valid <= 1'b0;
    else sq_valid <= sp_valid;
  end

  always_ff @(posedge clk) begin
    sq_item <= sq_item_next;
  end

  // bounce and output word
  logic [2:0][31:0] sr_vel;
  logic [2:0]       sr_out;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sr_out[i] = ($signed({sq_item.pos[i][31], sq_item.pos[i]}) <
                   -$signed({2'b00, world_extent})) ||
                  ($signed(sq_item.pos[i]) > $signed({1'b0, world_extent}));
      sr_vel[i] = sq_item.vel[i];
      if (sq_item.alive && sr_out[i] && !(i == 2 && lock_z)) begin
        sr_vel[i] = (sq_item.vel[i] == 32'h8000_0000) ? 32'h7fff_ffff
                                                      : (~sq_item.vel[i] + 32'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= sq_valid;
  end

  always_ff @(posedge clk) begin
    new_pos_x <= sq_item.pos[0];
    new_pos_y <= sq_item.pos[1];
    new_pos_z <= sq_item.pos[2];
    new_vel_x <= sr_vel[0];
    new_vel_y <= sr_vel[1];
    new_vel_z <= sr_vel[2];
  end

endmodule

FILE: test/tb_agent_seek_clamp_integrate_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_agent_seek_clamp_integrate_top
// Self-checking bench for the agent seek, clamp and integrate pipeline.
// A queue-fed driver issues agent words, with random gaps in all settings
// but one. A bit-exact predictor computes the updated position and velocity
// of each accepted word. A monitor compares every done strobe with the oldest
// prediction. The run steps through several register settings, the extremes
// among them, and writes registers only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_agent_seek_clamp_integrate_top;

  typedef struct {
    logic [31:0] pos [3];
    logic [31:0] vel [3];
    logic [31:0] tgt [3];
    logic        alive;
    logic [15:0] dt;
  } agent_t;

  typedef struct {
    logic [31:0] pos [3];
    logic [31:0] vel [3];
  } motion_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [31:0] pos_x = 0, pos_y = 0, pos_z = 0, vel_x = 0, vel_y = 0, vel_z = 0;
  logic [31:0] target_x = 0, target_y = 0, target_z = 0;
  logic        alive = 0;
  logic [15:0] time_step = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_addr = 0;
  logic [31:0] cfg_data = 0;
  logic        done;
  logic [31:0] new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z;

  agent_t  pending_agents [$];
  motion_t expected_motion [$];
  agent_t  cur_agent;
  int      errors = 0;
  int      gap = 0;
  bit      gaps_on = 1;

  // predictor copy of the registers
  longint unsigned m_max_speed = 39321600;
  longint unsigned m_extent = 655360000;
  longint unsigned m_accel = 0;
  bit              m_seek = 0;
  bit              m_lock = 0;
  longint          m_ground = 0;

  agent_seek_clamp_integrate_top DUT (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned magn(longint x);
    return (x < 0) ? longint'(-x) : x;
  endfunction

  function automatic longint signed_as(longint sgn, longint unsigned m);
    return (sgn < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic motion_t agent_update(agent_t a);
    longint p [3], v [3], t [3], d [3];
    longint unsigned m [3], mx, sum, n, u, g, s2, ms2, s, dt;
    bit far;
    motion_t r;
    dt = a.dt;
    for (int i = 0; i < 3; i++) begin
      p[i] = longint'($signed(a.pos[i]));
      v[i] = longint'($signed(a.vel[i]));
      t[i] = longint'($signed(a.tgt[i]));
    end
    if (a.alive) begin
      if (m_seek) begin
        mx = 0;
        far = 0;
        for (int i = 0; i < 3; i++) begin
          d[i] = (i == 2 && m_lock) ? 0 : t[i] - p[i];
          m[i] = magn(d[i]);
          if (m[i] > 65536) far = 1;
          if (m[i] > mx) mx = m[i];
        end
        if (!far) begin
          sum = 0;
          for (int i = 0; i < 3; i++) sum += m[i] * m[i];
          far = sum > 64'd4294967296;
        end
        if (far) begin
          sum = 0;
          for (int i = 0; i < 3; i++) begin
            if (mx >= 64'd2147483648) m[i] = m[i] >> 1;
            sum += m[i] * m[i];
          end
          n = root64(sum);
          if (n == 0) n = 1;
          for (int i = 0; i < 3; i++) begin
            if (!(i == 2 && m_lock)) begin
              u = (m[i] << 30) / n;
              g = (((u * m_accel) >> 30) * dt) >> 16;
              v[i] = clip32(v[i] + signed_as(d[i], g));
            end
          end
        end
      end
      s2 = 0;
      ms2 = m_max_speed * m_max_speed;
      for (int i = 0; i < 3; i++) s2 += magn(v[i]) * magn(v[i]);
      if (s2 > ms2) begin
        s = root64(s2);
        if (s == 0) s = 1;
        for (int i = 0; i < 3; i++) v[i] = clip32(signed_as(v[i], magn(v[i]) * m_max_speed / s));
      end
      for (int i = 0; i < 3; i++) p[i] = clip32(p[i] + signed_as(v[i], (magn(v[i]) * dt) >> 16));
      if (m_lock) begin
        p[2] = m_ground;
        v[2] = 0;
      end
      for (int i = 0; i < 3; i++) begin
        if (!(i == 2 && m_lock) && (p[i] < -longint'(m_extent) || p[i] > longint'(m_extent)))
          v[i] = clip32(-v[i]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      r.pos[i] = p[i][31:0];
      r.vel[i] = v[i][31:0];
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
    end else begin
      if (start && !busy) expected_motion.push_back(agent_update(cur_agent));
      if (start && busy) begin
        start <= 1;
      end else if (gap > 0) begin
        gap <= gap - 1;
        start <= 0;
      end else if (pending_agents.size() > 0) begin
        cur_agent = pending_agents.pop_front();
        pos_x <= cur_agent.pos[0];
        pos_y <= cur_agent.pos[1];
        pos_z <= cur_agent.pos[2];
        vel_x <= cur_agent.vel[0];
        vel_y <= cur_agent.vel[1];
        vel_z <= cur_agent.vel[2];
        target_x <= cur_agent.tgt[0];
        target_y <= cur_agent.tgt[1];
        target_z <= cur_agent.tgt[2];
        alive <= cur_agent.alive;
        time_step <= cur_agent.dt;
        start <= 1;
        gap <= gaps_on ? $urandom_range(0, 5) : 0;
      end else begin
        start <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    motion_t e;
    logic [31:0] got [6];
    if (!rst && done) begin
      got = '{new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z};
      if (expected_motion.size() == 0) begin
        $display("%0t: unexpected word on done", $time);
        errors++;
      end else begin
        e = expected_motion.pop_front();
        for (int i = 0; i < 6; i++) begin
          if (got[i] !== (i < 3 ? e.pos[i] : e.vel[i - 3])) begin
            $display("%0t: field %0d expected %h actual %h", $time, i,
                     (i < 3 ? e.pos[i] : e.vel[i - 3]), got[i]);
            errors++;
          end
        end
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_data <= val;
    unique case (idx)
      asci_pkg::REG_MAX_SPEED:    m_max_speed = val[30:0];
      asci_pkg::REG_WORLD_EXTENT: m_extent = val[30:0];
      asci_pkg::REG_SEEK_ACCEL:   m_accel = val[30:0];
      asci_pkg::REG_SEEK_ENABLE:  m_seek = val[0];
      asci_pkg::REG_LOCK_Z:       m_lock = val[0];
      asci_pkg::REG_GROUND_LEVEL: m_ground = longint'($signed(val));
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    while (pending_agents.size() > 0 || start || expected_motion.size() > 0)
      @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000);
      1, 2: return $urandom;
      default: return 32'(int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000);
    endcase
  endfunction

  function automatic agent_t rand_agent();
    agent_t a;
    for (int i = 0; i < 3; i++) begin
      a.pos[i] = rand_word();
      a.vel[i] = rand_word();
      a.tgt[i] = ($urandom_range(0, 5) == 0) ? a.pos[i] + $urandom_range(0, 40000) : rand_word();
    end
    a.alive = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 7))
      0: a.dt = 0;
      1: a.dt = 16'hffff;
      default: a.dt = 16'($urandom);
    endcase
    return a;
  endfunction

  function automatic agent_t mk(logic [31:0] p, logic [31:0] v, logic [31:0] t,
                                logic al, logic [15:0] dt);
    agent_t a;
    a.pos = '{p, p, p};
    a.vel = '{v, -v, v};
    a.tgt = '{t, t, t};
    a.alive = al;
    a.dt = dt;
    return a;
  endfunction

  initial begin
    logic [31:0] cfgs [6][7];
    cfgs[0] = '{32'd39321600, 32'd655360000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    cfgs[1] = '{32'd39321600, 32'd655360000, 32'd6553600, 32'd1, 32'd0, 32'd0, 32'd0};
    cfgs[2] = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1, 32'd1, 32'h8000_0000, 32'd0};
    cfgs[3] = '{32'd0, 32'd0, 32'd65536, 32'd0, 32'd1, 32'h7fff_ffff, 32'd0};
    cfgs[4] = '{32'd1310720, 32'd6553600, 32'd13107200, 32'd1, 32'd0, 32'd0, 32'd0};
    cfgs[5] = '{32'hffff_ffff, 32'd65536, 32'd0, 32'd1, 32'd1, 32'h0001_0000, 32'd0};
    repeat (6) @(posedge clk);
    rst <= 0;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        for (int r = 0; r < 6; r++) reg_write(r[2:0], cfgs[ph][r]);
        reg_write(3'd6, $urandom);
        reg_write(3'd7, $urandom);
      end
      gaps_on = (ph != 3);
      if (ph < 2) begin
        pending_agents.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1, 16'hffff));
        pending_agents.push_back(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1, 16'hffff));
        pending_agents.push_back(mk(32'h1234_5678, 32'h8000_0000, 32'd0, 0, 16'hffff));
        pending_agents.push_back(mk(32'd0, 32'h0100_0000, 32'd0, 1, 16'd0));
        pending_agents.push_back(mk(32'd0, 32'd0, 32'd65536, 1, 16'h8000));
        pending_agents.push_back(mk(32'd0, 32'd0, 32'd65537, 1, 16'h8000));
        pending_agents.push_back(mk(32'd0, 32'd100, 32'd46341, 1, 16'h8000));
        pending_agents.push_back(mk(32'h2700_0000, 32'h0200_0000, 32'd0, 1, 16'hffff));
        pending_agents.push_back(mk(32'hd900_0000, 32'h8000_0000, 32'h7fff_ffff, 1, 16'h1));
        pending_agents.push_back(mk(32'd0, 32'd0, 32'd0, 1, 16'hffff));
      end
      for (int k = 0; k < 65; k++) pending_agents.push_back(rand_agent());
      drain();
    end
    repeat (160) @(posedge clk);
    if (errors == 0 && expected_motion.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
src/asci_pkg.sv
src/asci_delay.sv
src/asci_sqrt.sv
src/asci_div.sv
src/agent_seek_clamp_integrate_top.sv
test/tb_agent_seek_clamp_integrate_top.sv
